FILE: hw/rtl/ffrd_pkg.sv
// Shared types and constants for the fixed frame resync decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ffrd_pkg;

   localparam int FRAME_BYTES = 18;
   localparam int BODY_BYTES  = FRAME_BYTES - 2;
   localparam int FILL_W      = 5;

   typedef logic [7:0] octet_type;

   typedef enum logic {
      CSR_HEADER = 1'b0,
      CSR_FOOTER = 1'b1
   } csr_index_type;

   localparam octet_type HEADER_RESET = 8'hAA;
   localparam octet_type FOOTER_RESET = 8'h55;

   // Frame bytes 1 through 16; element 0 holds frame byte 1.
   typedef struct packed {
      logic [BODY_BYTES-1:0][7:0] body;
   } frame_type;

endpackage

FILE: hw/rtl/ffrd_front.sv
// Front end: byte window, fill count, header and footer registers, frame match.
// Depends on ffrd_pkg; pushes matched frames into ffrd_queue.
`timescale 1ns / 1ps

module ffrd_front import ffrd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_index,
   input  logic [7:0]      csr_write_data,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_rx_byte,
   input  logic            queue_full,
   output logic            push_valid,
   output frame_type       push_frame
);

   octet_type               header_ff, header_in;
   octet_type               footer_ff, footer_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   octet_type               window_ff [FRAME_BYTES-1];
   logic                    accept;
   logic                    full;
   logic                    match;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == FILL_W'(FRAME_BYTES - 1));
   assign match     = full && (window_ff[0] == header_ff) && (req_rx_byte == footer_ff);
   assign push_valid = accept && match;

   always_comb begin
      for (int k = 0; k < BODY_BYTES; k++) begin
         push_frame.body[k] = window_ff[k + 1];
      end
   end

   always_comb begin
      header_in = header_ff;
      footer_in = footer_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEADER: header_in = csr_write_data;
            CSR_FOOTER: footer_in = csr_write_data;
         endcase
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         priority if (match) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            fill_in = fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         footer_ff <= FOOTER_RESET;
         fill_ff   <= '0;
      end else begin
         header_ff <= header_in;
         footer_ff <= footer_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < FRAME_BYTES - 2; k++) begin
            window_ff[k] <= window_ff[k + 1];
         end
         window_ff[FRAME_BYTES - 2] <= req_rx_byte;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_BYTES - 1))
      else $error("fill count beyond window");

   a_push_needs_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (full && !queue_full))
      else $error("frame pushed without a full window or into a full queue");

   a_push_empties: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> (fill_ff == '0))
      else $error("window not emptied after a frame");

   a_stall_holds_fill: assert property (@(posedge clock) disable iff (reset)
      !accept && !csr_write_enable |=> $stable(fill_ff))
      else $error("fill count moved without a beat");

endmodule

FILE: hw/rtl/ffrd_queue.sv
// Short frame queue between the front end and the output stage.
// Depends on ffrd_pkg for the frame type.
`timescale 1ns / 1ps

module ffrd_queue import ffrd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  frame_type  push_frame,
   output logic       full,
   output logic       pop_valid,
   input  logic       pop_ready,
   output frame_type  pop_frame
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_frame = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

FILE: hw/rtl/ffrd_back.sv
// Output stage: takes a frame from the queue, unpacks the fields and holds the beat.
// Depends on ffrd_pkg for the frame type.
`timescale 1ns / 1ps

module ffrd_back import ffrd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  frame_type           pop_frame,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_key0,
   output logic [7:0]          rsp_key1,
   output logic [7:0]          rsp_key2,
   output logic [7:0]          rsp_key3,
   output logic signed [15:0]  rsp_left_x,
   output logic signed [15:0]  rsp_left_y,
   output logic signed [15:0]  rsp_right_x,
   output logic signed [15:0]  rsp_right_y,
   output logic signed [15:0]  rsp_dial_value,
   output logic [7:0]          rsp_switch_a,
   output logic [7:0]          rsp_switch_b
);

   logic        valid_ff, valid_in;
   logic        load;
   logic [15:0] left_y_raw;

   assign load       = pop_valid && (!valid_ff || !rsp_stall);
   assign pop_ready  = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign left_y_raw = {pop_frame.body[6], pop_frame.body[7]};

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_key0       <= pop_frame.body[0];
         rsp_key1       <= pop_frame.body[1];
         rsp_key2       <= pop_frame.body[2];
         rsp_key3       <= pop_frame.body[3];
         rsp_left_x     <= {pop_frame.body[4], pop_frame.body[5]};
         rsp_left_y     <= 16'(16'h0000 - left_y_raw);
         rsp_right_x    <= {pop_frame.body[8], pop_frame.body[9]};
         rsp_right_y    <= {pop_frame.body[10], pop_frame.body[11]};
         rsp_dial_value <= {pop_frame.body[12], pop_frame.body[13]};
         rsp_switch_a   <= pop_frame.body[14];
         rsp_switch_b   <= pop_frame.body[15];
      end
   end

endmodule

FILE: hw/rtl/fixed_frame_resync_decoder_core.sv
// A frame's result beat is registered in the frame queue, then in the output stage register.
// Throughput: one byte per cycle while req_stall is low.
// The input stalls only when the frame queue is full.
// Reset is synchronous and active high: it empties the window and the queue, drops any
// pending result and restores the header to 0xAA and the footer to 0x55.
`timescale 1ns / 1ps

module fixed_frame_resync_decoder_core import ffrd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [7:0]          csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_key0,
   output logic [7:0]          rsp_key1,
   output logic [7:0]          rsp_key2,
   output logic [7:0]          rsp_key3,
   output logic signed [15:0]  rsp_left_x,
   output logic signed [15:0]  rsp_left_y,
   output logic signed [15:0]  rsp_right_x,
   output logic signed [15:0]  rsp_right_y,
   output logic signed [15:0]  rsp_dial_value,
   output logic [7:0]          rsp_switch_a,
   output logic [7:0]          rsp_switch_b
);

   logic      queue_full;
   logic      push_valid;
   frame_type push_frame;
   logic      pop_valid;
   logic      pop_ready;
   frame_type pop_frame;

   ffrd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_frame       (push_frame)
   );

   ffrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   ffrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_frame      (pop_frame),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key0       (rsp_key0),
      .rsp_key1       (rsp_key1),
      .rsp_key2       (rsp_key2),
      .rsp_key3       (rsp_key3),
      .rsp_left_x     (rsp_left_x),
      .rsp_left_y     (rsp_left_y),
      .rsp_right_x    (rsp_right_x),
      .rsp_right_y    (rsp_right_y),
      .rsp_dial_value (rsp_dial_value),
      .rsp_switch_a   (rsp_switch_a),
      .rsp_switch_b   (rsp_switch_b)
   );

endmodule

FILE: bench/tb_fixed_frame_resync_decoder_core.sv
// Self-checking bench for fixed_frame_resync_decoder_core: bytes in, decoded frames out.
// A local predictor of the byte window forecasts each frame; depends on ffrd_pkg and the core.
`timescale 1ns / 1ps

module tb_fixed_frame_resync_decoder_core;
   import ffrd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      octet_type         key [4];
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] dial_value;
      octet_type         switch_a;
      octet_type         switch_b;
   } decoded_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_HEADER;
   logic [7:0] csr_write_data = 8'h00;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_key0, rsp_key1, rsp_key2, rsp_key3;
   logic signed [15:0] rsp_left_x, rsp_left_y, rsp_right_x, rsp_right_y, rsp_dial_value;
   logic [7:0] rsp_switch_a, rsp_switch_b;

   octet_type         pending_bytes [$];
   decoded_frame_type expected_frames [$];
   octet_type         window_bytes [FRAME_BYTES];
   int unsigned       window_fill = 0;
   octet_type         header_value = HEADER_RESET;
   octet_type         footer_value = FOOTER_RESET;
   int unsigned       bytes_queued = 0;
   int unsigned       bytes_accepted = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                req_taken = 1'b0;
   bit                calm = 1'b0;

   fixed_frame_resync_decoder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key0         (rsp_key0),
      .rsp_key1         (rsp_key1),
      .rsp_key2         (rsp_key2),
      .rsp_key3         (rsp_key3),
      .rsp_left_x       (rsp_left_x),
      .rsp_left_y       (rsp_left_y),
      .rsp_right_x      (rsp_right_x),
      .rsp_right_y      (rsp_right_y),
      .rsp_dial_value   (rsp_dial_value),
      .rsp_switch_a     (rsp_switch_a),
      .rsp_switch_b     (rsp_switch_b)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] window_word(int unsigned pos);
      return {window_bytes[pos], window_bytes[pos + 1]};
   endfunction

   task automatic absorb_byte(octet_type b);
      decoded_frame_type frame;
      window_bytes[window_fill] = b;
      window_fill++;
      if (window_fill == FRAME_BYTES) begin
         if (window_bytes[0] == header_value && window_bytes[FRAME_BYTES-1] == footer_value) begin
            for (int i = 0; i < 4; i++) frame.key[i] = window_bytes[i + 1];
            frame.left_x     = window_word(5);
            frame.left_y     = ~window_word(7) + 16'd1;
            frame.right_x    = window_word(9);
            frame.right_y    = window_word(11);
            frame.dial_value = window_word(13);
            frame.switch_a   = window_bytes[15];
            frame.switch_b   = window_bytes[16];
            expected_frames.push_back(frame);
            window_fill = 0;
         end else begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) window_bytes[i] = window_bytes[i + 1];
            window_fill = FRAME_BYTES - 1;
         end
      end
   endtask

   function automatic void check_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %h, actual %h", name, expv, actv);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      decoded_frame_type exp_frame;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $error("result beat with no frame expected");
               mismatch_count++;
            end else begin
               exp_frame = expected_frames.pop_front();
               check_field("key0", 16'(exp_frame.key[0]), 16'(rsp_key0));
               check_field("key1", 16'(exp_frame.key[1]), 16'(rsp_key1));
               check_field("key2", 16'(exp_frame.key[2]), 16'(rsp_key2));
               check_field("key3", 16'(exp_frame.key[3]), 16'(rsp_key3));
               check_field("left_x", exp_frame.left_x, rsp_left_x);
               check_field("left_y", exp_frame.left_y, rsp_left_y);
               check_field("right_x", exp_frame.right_x, rsp_right_x);
               check_field("right_y", exp_frame.right_y, rsp_right_y);
               check_field("dial_value", exp_frame.dial_value, rsp_dial_value);
               check_field("switch_a", 16'(exp_frame.switch_a), 16'(rsp_switch_a));
               check_field("switch_b", 16'(exp_frame.switch_b), 16'(rsp_switch_b));
            end
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_rx_byte);
            bytes_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !calm && !reset && ($urandom_range(0, 99) < 31);
   end

   task automatic queue_byte(octet_type b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(octet_type hdr, octet_type ftr);
      queue_byte(hdr);
      for (int i = 0; i < BODY_BYTES; i++) queue_byte(octet_type'($urandom));
      queue_byte(ftr);
   endtask

   task automatic queue_random_phase(int unsigned count);
      int unsigned start;
      int unsigned roll;
      octet_type   flip;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         roll = $urandom_range(0, 99);
         flip = octet_type'($urandom_range(1, 255));
         if (roll < 70) begin
            queue_frame(header_value, footer_value);
         end else if (roll < 78) begin
            queue_frame(header_value, footer_value ^ flip);
         end else if (roll < 86) begin
            queue_frame(header_value ^ flip, footer_value);
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(octet_type'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || expected_frames.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, octet_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_HEADER) header_value = value;
      else footer_value = value;
   endtask

   task automatic run_phase(octet_type hdr, octet_type ftr, bit no_idle, int unsigned count);
      write_csr(CSR_HEADER, hdr);
      write_csr(CSR_FOOTER, ftr);
      calm = no_idle;
      queue_random_phase(count);
      wait_idle();
      calm = 1'b0;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme frame: axes at both signed limits, and left_y negating the most negative value.
      queue_byte(HEADER_RESET);
      queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h80); queue_byte(8'h7F);
      queue_byte(8'h80); queue_byte(8'h00);
      queue_byte(8'h80); queue_byte(8'h00);
      queue_byte(8'h7F); queue_byte(8'hFF);
      queue_byte(8'hFF); queue_byte(8'hFF);
      queue_byte(8'h00); queue_byte(8'h01);
      queue_byte(8'h00); queue_byte(8'hFF);
      queue_byte(FOOTER_RESET);
      // A partial window that carries over into the next setting.
      queue_byte(HEADER_RESET); queue_byte(FOOTER_RESET);
      queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h04); queue_byte(8'h08);
      wait_idle();

      run_phase(HEADER_RESET, FOOTER_RESET, 1'b0, 160);
      run_phase(8'h00, 8'hFF, 1'b1, 160);
      run_phase(8'hFF, 8'h00, 1'b0, 160);
      run_phase(octet_type'($urandom), octet_type'($urandom), 1'b0, 160);
      begin
         octet_type same;
         same = octet_type'($urandom);
         run_phase(same, same, 1'b0, 160);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: fixed_frame_resync_decoder_core.f
hw/rtl/ffrd_pkg.sv
hw/rtl/ffrd_front.sv
hw/rtl/ffrd_queue.sv
hw/rtl/ffrd_back.sv
hw/rtl/fixed_frame_resync_decoder_core.sv
bench/tb_fixed_frame_resync_decoder_core.sv
